FILE: design/pf_pkg.sv
package pf_pkg;

  localparam int LETTERS     = 26;
  localparam int CELLS       = 25;
  localparam int SIDE        = 5;
  localparam int CFG_W       = 5;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] coord_t;

  localparam letter_t LETTER_I     = 5'd8;
  localparam letter_t LETTER_J     = 5'd9;
  localparam letter_t LETTER_Z     = 5'd25;
  localparam letter_t FILLER_RESET = 5'd23;

  typedef enum logic [1:0] {
    OP_KEY,
    OP_KEY_END,
    OP_TEXT,
    OP_TEXT_END
  } op_t;

  typedef struct packed {
    op_t     op;
    letter_t letter;
  } pf_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQ,
    ST_EMIT,
    ST_FILL
  } state_t;

  typedef enum logic {
    CFG_DECRYPT = 1'b0,
    CFG_FILLER  = 1'b1
  } cfg_idx_t;

  // saturate above z, fold j onto i
  function automatic letter_t norm_letter(letter_t v);
    letter_t l;
    l = (v > LETTER_Z) ? LETTER_Z : v;
    if (l == LETTER_J) begin
      l = LETTER_I;
    end
    return l;
  endfunction

  function automatic coord_t pos_row(letter_t p);
    coord_t r;
    if (p >= 5'd20) begin
      r = 3'd4;
    end else if (p >= 5'd15) begin
      r = 3'd3;
    end else if (p >= 5'd10) begin
      r = 3'd2;
    end else if (p >= 5'd5) begin
      r = 3'd1;
    end else begin
      r = 3'd0;
    end
    return r;
  endfunction

  // row * 5 + col
  function automatic letter_t cell_addr(coord_t r, coord_t c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

  function automatic coord_t pos_col(letter_t p);
    letter_t d;
    d = p - cell_addr(pos_row(p), 3'd0);
    return d[2:0];
  endfunction

  function automatic coord_t shift_coord(coord_t c, logic dec);
    coord_t n;
    if (dec) begin
      n = (c == 3'd0) ? 3'(SIDE - 1) : c - 3'd1;
    end else begin
      n = (c == 3'(SIDE - 1)) ? 3'd0 : c + 3'd1;
    end
    return n;
  endfunction

endpackage

FILE: design/pf_chan_if.sv
interface pf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [4:0] letter;
  logic       last;

  modport source (output valid, output kind, output letter, output last, input ready);
  modport sink   (input valid, input kind, input letter, input last, output ready);
endinterface

interface pf_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] first_out;
  logic [4:0] second_out;
  logic       last_pair;

  modport source (output valid, output first_out, output second_out, output last_pair,
                  input ready);
  modport sink   (input valid, input first_out, input second_out, input last_pair,
                  output ready);
endinterface

FILE: design/pf_front.sv
module pf_front #(
  parameter int QUEUE_DEPTH = pf_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  pf_in_if.sink            in_ch,
  output pf_pkg::pf_item_t head,
  output logic             head_valid,
  input  logic             pop
);
  import pf_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pf_item_t           q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  pf_item_t           item;
  logic               push;
  logic               do_pop;

  always_comb begin
    item.letter = norm_letter(in_ch.letter);
    if (in_ch.kind) begin
      item.op = in_ch.last ? OP_TEXT_END : OP_TEXT;
    end else begin
      item.op = in_ch.last ? OP_KEY_END : OP_KEY;
    end
  end

  assign in_ch.ready = (count_r != CNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign head_valid  = (count_r != '0);
  assign do_pop      = pop && head_valid;
  assign head        = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

FILE: design/pf_back.sv
module pf_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [pf_pkg::CFG_W-1:0] cfg_data,
  input  pf_pkg::pf_item_t         head,
  input  logic                     head_valid,
  output logic                     pop,
  pf_out_if.source                 out_ch
);
  import pf_pkg::*;

  state_t                state_r, state_nxt;
  logic [LETTERS-1:0]    used_r, used_nxt, used_base;
  letter_t               fill_r, fill_nxt, fill_base;
  letter_t               held_r, held_nxt;
  logic                  have_held_r, have_held_nxt;
  logic                  key_done_r, key_done_nxt;
  letter_t               sweep_r, sweep_nxt;
  logic                  decrypt_r;
  letter_t               filler_r;
  logic                  out_valid_r;
  letter_t               out_first_r, out_second_r;
  logic                  out_last_r;
  logic                  pair_last_r;
  letter_t               pos_a_r, pos_b_r;
  letter_t               sq_a_r, sq_b_r;

  letter_t               square_mem [CELLS];
  letter_t               pos_mem [LETTERS];

  logic                  is_key, is_end;
  logic                  start_key, place_try, place_ok;
  letter_t               place_letter;
  logic                  hold_go, pair_go, out_load;
  letter_t               fill_l, pair_a, pair_b;
  coord_t                ra, ca, rb, cb;
  coord_t                ra_n, ca_n, rb_n, cb_n;
  letter_t               addr_a, addr_b;

  assign fill_l = norm_letter(filler_r);
  assign is_key = (head.op == OP_KEY) || (head.op == OP_KEY_END);
  assign is_end = (head.op == OP_KEY_END) || (head.op == OP_TEXT_END);

  // control outputs
  always_comb begin
    pop          = 1'b0;
    start_key    = 1'b0;
    place_try    = 1'b0;
    place_letter = head.letter;
    hold_go      = 1'b0;
    pair_go      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          if (is_key) begin
            start_key = 1'b1;
            place_try = 1'b1;
          end else if (key_done_r) begin
            if (!have_held_r && !is_end) begin
              hold_go = 1'b1;
            end else begin
              pair_go = 1'b1;
            end
          end
        end
      end
      ST_FILL: begin
        place_try    = (sweep_r != LETTER_J);
        place_letter = sweep_r;
      end
      default: begin
      end
    endcase
  end

  assign out_load = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);

  // a new key after a finished one starts from an empty square
  assign used_base = (start_key && key_done_r) ? '0 : used_r;
  assign fill_base = (start_key && key_done_r) ? '0 : fill_r;
  assign place_ok  = place_try && (fill_base < 5'(CELLS)) && !used_base[place_letter];

  always_comb begin
    if (have_held_r) begin
      pair_a = held_r;
      pair_b = (!decrypt_r && (held_r == head.letter)) ? fill_l : head.letter;
    end else begin
      pair_a = head.letter;
      pair_b = fill_l;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (head_valid && (head.op == OP_KEY_END)) begin
          state_nxt = ST_FILL;
        end else if (pair_go) begin
          state_nxt = ST_SQ;
        end
      end
      ST_SQ:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_FILL: begin
        if (sweep_r == LETTER_Z) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    used_nxt      = used_base;
    fill_nxt      = fill_base;
    held_nxt      = held_r;
    have_held_nxt = have_held_r;
    key_done_nxt  = key_done_r;
    sweep_nxt     = (state_r == ST_FILL) ? sweep_r + 5'd1 : '0;
    if (place_ok) begin
      used_nxt[place_letter] = 1'b1;
      fill_nxt               = fill_base + 5'd1;
    end
    if (start_key) begin
      key_done_nxt = 1'b0;
      if (key_done_r) begin
        held_nxt      = '0;
        have_held_nxt = 1'b0;
      end
    end
    if ((state_r == ST_FILL) && (sweep_r == LETTER_Z)) begin
      key_done_nxt = 1'b1;
    end
    if (hold_go) begin
      held_nxt      = head.letter;
      have_held_nxt = 1'b1;
    end
    if (pair_go) begin
      held_nxt      = '0;
      have_held_nxt = 1'b0;
    end
  end

  // row, column and rectangle rules on the fetched positions
  always_comb begin
    ra   = pos_row(pos_a_r);
    ca   = pos_col(pos_a_r);
    rb   = pos_row(pos_b_r);
    cb   = pos_col(pos_b_r);
    ra_n = ra;
    rb_n = rb;
    ca_n = cb;
    cb_n = ca;
    if (ra == rb) begin
      ca_n = shift_coord(ca, decrypt_r);
      cb_n = shift_coord(cb, decrypt_r);
    end else if (ca == cb) begin
      ca_n = ca;
      cb_n = cb;
      ra_n = shift_coord(ra, decrypt_r);
      rb_n = shift_coord(rb, decrypt_r);
    end
    addr_a = cell_addr(ra_n, ca_n);
    addr_b = cell_addr(rb_n, cb_n);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      used_r      <= '0;
      fill_r      <= '0;
      held_r      <= '0;
      have_held_r <= 1'b0;
      key_done_r  <= 1'b0;
      sweep_r     <= '0;
      decrypt_r   <= 1'b0;
      filler_r    <= FILLER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      fill_r      <= fill_nxt;
      held_r      <= held_nxt;
      have_held_r <= have_held_nxt;
      key_done_r  <= key_done_nxt;
      sweep_r     <= sweep_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_DECRYPT: decrypt_r <= cfg_data[0];
          CFG_FILLER:  filler_r  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pair_go) begin
      pair_last_r <= is_end;
    end
    if (out_load) begin
      out_first_r  <= sq_a_r;
      out_second_r <= sq_b_r;
      out_last_r   <= pair_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (place_ok) begin
      square_mem[fill_base] <= place_letter;
      pos_mem[place_letter] <= fill_base;
    end
    if (pair_go) begin
      pos_a_r <= pos_mem[pair_a];
      pos_b_r <= pos_mem[pair_b];
    end
    if (state_r == ST_SQ) begin
      sq_a_r <= square_mem[addr_a];
      sq_b_r <= square_mem[addr_b];
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.first_out  = out_first_r;
  assign out_ch.second_out = out_second_r;
  assign out_ch.last_pair  = out_last_r;

`ifndef NO_ASSERTIONS
  a_used_matches_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(used_r) == int'(fill_r))
    else $error("used set and fill count disagree");

  a_done_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    key_done_r |-> (fill_r == 5'(CELLS)))
    else $error("square marked complete but not full");

  a_no_pop_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> !pop)
    else $error("queue popped during alphabet fill");

  a_lookup_needs_key: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ) |-> key_done_r)
    else $error("square lookup before key complete");
`endif

endmodule

FILE: design/playfair_digraph_cipher.sv
// channel  | dir | handshake    | payload
// in_ch    | in  | valid/ready  | kind, letter, last
// out_ch   | out | valid/ready  | first_out, second_out, last_pair
// cfg      | in  | cfg_we only  | cfg_index (0 decrypt_mode, 1 filler_letter), cfg_data
//
// Key letter: placed in the square, if new, as it is popped; the last key letter adds an alphabet sweep.
// Text letter: the first of a pair is held; the second runs the position read, the square read and
// the output load in turn, and the back end pops no new letter until that pair is loaded.
// Synchronous active-low reset; square and position tables are not cleared.
// The input queue keeps accepting while a result waits in the output register.
module playfair_digraph_cipher #(
  parameter int QUEUE_DEPTH = pf_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  pf_in_if.sink                    in_ch,
  pf_out_if.source                 out_ch,
  input  logic                     cfg_we,
  input  logic                     cfg_index,
  input  logic [pf_pkg::CFG_W-1:0] cfg_data
);
  import pf_pkg::*;

  pf_item_t head;
  logic     head_valid;
  logic     pop;

  pf_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  pf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
